### design/spr_pkg.sv
package spr_pkg;

	localparam int BLK_W      = 10;
	localparam int SUM_W      = 12;
	localparam int DIFF_W     = 13;
	localparam int PASS_W     = 7;
	localparam int SLICES     = 3;

	typedef logic [BLK_W-1:0] blk_t;

	localparam blk_t RST_TOTAL  = 10'd100;
	localparam blk_t RST_INIT0  = 10'd34;
	localparam blk_t RST_INIT1  = 10'd33;
	localparam blk_t RST_INIT2  = 10'd33;
	localparam blk_t MAX_BLOCKS = 10'd1023;

	localparam logic [4:0]        ACTION_COUNT = 5'd27;
	localparam logic [PASS_W-1:0] PASS_LIMIT   = 7'd100;

	typedef enum logic [1:0] {
		REG_TOTAL = 2'd0,
		REG_INIT0 = 2'd1,
		REG_INIT1 = 2'd2,
		REG_INIT2 = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SUM,
		ST_REPAIR,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic load_init;
		logic apply_delta;
		logic calc_diff;
		logic grow;
		logic shrink;
		logic set_acc;
		logic set_fb;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic op;
		logic act_ok;
		logic diff_pos;
		logic diff_neg;
		logic shrink_fail;
	} sts_t;

	// base-3 digits of an action id, slice 0 most significant
	function automatic logic [2:0][1:0] action_digits(input logic [4:0] act);
		logic [2:0][1:0] d;
		logic [4:0]      r;
		d = '0;
		if (act >= 5'd18) begin
			d[0] = 2'd2;
			r    = act - 5'd18;
		end else if (act >= 5'd9) begin
			d[0] = 2'd1;
			r    = act - 5'd9;
		end else begin
			d[0] = 2'd0;
			r    = act;
		end
		if (r >= 5'd6) begin
			d[1] = 2'd2;
			d[2] = 2'(r - 5'd6);
		end else if (r >= 5'd3) begin
			d[1] = 2'd1;
			d[2] = 2'(r - 5'd3);
		end else begin
			d[1] = 2'd0;
			d[2] = r[1:0];
		end
		return d;
	endfunction

endpackage

### design/spr_ctrl.sv
module spr_ctrl
	import spr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				if (sts.op || !sts.act_ok) state_d = ST_DONE;
				else                       state_d = ST_SUM;
			end
			ST_SUM: state_d = ST_REPAIR;
			ST_REPAIR: begin
				if (sts.diff_pos) state_d = ST_REPAIR;
				else if (sts.diff_neg) begin
					if (sts.shrink_fail) state_d = ST_DONE;
				end else state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
			end
			ST_DECODE: begin
				if (sts.op) begin
					cmd.load_init = 1'b1;
					cmd.set_acc   = 1'b1;
				end else if (sts.act_ok) begin
					cmd.apply_delta = 1'b1;
					cmd.set_acc     = 1'b1;
				end
			end
			ST_SUM: cmd.calc_diff = 1'b1;
			ST_REPAIR: begin
				if (sts.diff_pos) cmd.grow = 1'b1;
				else if (sts.diff_neg) begin
					if (sts.shrink_fail) begin
						cmd.load_init = 1'b1;
						cmd.set_fb    = 1'b1;
					end else cmd.shrink = 1'b1;
				end
			end
			ST_DONE: cmd.load_out = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)    out_valid_q <= 1'b1;
			else if (m_tready)   out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

### design/spr_dpath.sv
module spr_dpath
	import spr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_data,
	input  logic [7:0]  s_tdata,
	input  logic [0:0]  s_tuser,
	output logic [31:0] m_tdata,
	output logic [1:0]  m_tuser,
	input  cmd_t        cmd,
	output sts_t        sts
);

	blk_t                   total_q;
	blk_t [SLICES-1:0]      init_q;
	blk_t [SLICES-1:0]      alloc_q;
	logic                   op_q;
	logic [4:0]             act_q;
	logic [1:0]             rot_q;
	logic                   acc_q, fb_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic [1:0]             pos_q;
	logic                   removed_q;
	logic [PASS_W-1:0]      passes_q;
	blk_t [SLICES-1:0]      res_alloc_q;
	logic                   res_acc_q, res_fb_q;

	logic [2:0][1:0]        digits;
	blk_t [SLICES-1:0]      delta_alloc;
	logic [SUM_W-1:0]       alloc_sum;
	logic signed [DIFF_W-1:0] diff_calc;
	logic [1:0]             min_idx;
	logic [2:0]             rot_pos;
	logic [1:0]             shr_idx;
	logic                   can_rm;
	logic signed [DIFF_W-1:0] diff_shr;
	logic                   pass_end;
	logic                   removed_any;

	// delta with floor of one and ceiling of max blocks
	always_comb begin
		logic [BLK_W:0] sum1;
		logic [BLK_W:0] dec1;
		digits = action_digits(act_q);
		for (int s = 0; s < SLICES; s++) begin
			sum1 = {1'b0, alloc_q[s]} + {9'b0, digits[s]};
			dec1 = sum1 - 11'd1;
			if (sum1 <= 11'd1)        delta_alloc[s] = 10'd1;
			else if (dec1[BLK_W])     delta_alloc[s] = MAX_BLOCKS;
			else                      delta_alloc[s] = dec1[BLK_W-1:0];
		end
	end

	assign alloc_sum = {2'b0, alloc_q[0]} + {2'b0, alloc_q[1]} + {2'b0, alloc_q[2]};
	assign diff_calc = $signed({3'b0, total_q}) - $signed({1'b0, alloc_sum});

	// smallest slice, lowest index on ties
	always_comb begin
		min_idx = 2'd0;
		if (alloc_q[1] < alloc_q[0]) min_idx = 2'd1;
		if (alloc_q[2] < alloc_q[min_idx]) min_idx = 2'd2;
	end

	// one slice of a removal pass per cycle
	assign rot_pos     = {1'b0, rot_q} + {1'b0, pos_q};
	assign shr_idx     = (rot_pos >= 3'd3) ? 2'(rot_pos - 3'd3) : rot_pos[1:0];
	assign can_rm      = alloc_q[shr_idx] > 10'd1;
	assign diff_shr    = diff_q + $signed({{(DIFF_W-1){1'b0}}, can_rm});
	assign pass_end    = (pos_q == 2'd2) || (diff_shr == '0);
	assign removed_any = removed_q || can_rm;

	assign sts.op          = op_q;
	assign sts.act_ok      = act_q < ACTION_COUNT;
	assign sts.diff_pos    = diff_q > 0;
	assign sts.diff_neg    = diff_q < 0;
	assign sts.shrink_fail = pass_end && (!removed_any || passes_q == PASS_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= RST_TOTAL;
			init_q  <= {RST_INIT2, RST_INIT1, RST_INIT0};
			alloc_q <= {RST_INIT2, RST_INIT1, RST_INIT0};
		end else begin
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_TOTAL: total_q   <= cfg_data;
					REG_INIT0: init_q[0] <= cfg_data;
					REG_INIT1: init_q[1] <= cfg_data;
					REG_INIT2: init_q[2] <= cfg_data;
					default:   total_q   <= total_q;
				endcase
			end
			priority if (cmd.load_init) alloc_q <= init_q;
			else if (cmd.apply_delta)   alloc_q <= delta_alloc;
			else if (cmd.grow)          alloc_q[min_idx] <= alloc_q[min_idx] + 10'd1;
			else if (cmd.shrink && can_rm) alloc_q[shr_idx] <= alloc_q[shr_idx] - 10'd1;
			else                        alloc_q <= alloc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= 1'b0;
			fb_q      <= 1'b0;
			pos_q     <= 2'd0;
			removed_q <= 1'b0;
			passes_q  <= '0;
		end else begin
			if (cmd.capture) begin
				acc_q <= 1'b0;
				fb_q  <= 1'b0;
			end else begin
				if (cmd.set_acc) acc_q <= 1'b1;
				if (cmd.set_fb)  fb_q  <= 1'b1;
			end
			if (cmd.calc_diff) begin
				pos_q     <= 2'd0;
				removed_q <= 1'b0;
				passes_q  <= '0;
			end else if (cmd.shrink) begin
				if (pass_end) begin
					pos_q     <= 2'd0;
					removed_q <= 1'b0;
					passes_q  <= passes_q + PASS_W'(removed_any);
				end else begin
					pos_q     <= pos_q + 2'd1;
					removed_q <= removed_any;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= s_tuser[0];
			act_q <= s_tdata[4:0];
			rot_q <= (s_tdata[6:5] == 2'd3) ? 2'd0 : s_tdata[6:5];
		end
		priority if (cmd.calc_diff) diff_q <= diff_calc;
		else if (cmd.grow)          diff_q <= diff_q - 13'sd1;
		else if (cmd.shrink)        diff_q <= diff_shr;
		else                        diff_q <= diff_q;
		if (cmd.load_out) begin
			res_alloc_q <= alloc_q;
			res_acc_q   <= acc_q;
			res_fb_q    <= fb_q;
		end
	end

	assign m_tdata = {2'b0, res_alloc_q[2], res_alloc_q[1], res_alloc_q[0]};
	assign m_tuser = {res_fb_q, res_acc_q};

endmodule

### design/slice_prb_rebalancer.sv
// reload or out-of-range action: decode, then done, then the result register
// apply: decode, sum, then one repair step per block added by the grow
//   loop (at most 1020) or per slice visited by the removal passes (at most 303)
// throughput: one transaction at a time, next accepted once the result is registered
// arst_n low clears control state and loads the reset configuration and allocation
module slice_prb_rebalancer
	import spr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [4:0] action_id, [6:5] rotation_start, [7] zero
	input  logic [0:0]  s_tuser,   // [0] op
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [9:0] alloc_slice0, [19:10] alloc_slice1,
	                               // [29:20] alloc_slice2, [31:30] zero
	output logic [1:0]  m_tuser    // [0] accepted, [1] fell_back
);

	cmd_t cmd;
	sts_t sts;

	// sequencer: decode, sum, repair loop, hand off to the output register
	spr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// allocation state, configuration, repair arithmetic and result register
	spr_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.sts       (sts)
	);

`ifndef SYNTHESIS
	// a fallback only ever follows an applied action
	a_fb_implies_acc: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[0] || !m_tuser[1]))
		else $error("fell_back set without accepted");

	// the block is busy right after taking a transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while still busy");

	// a new result is registered in a cycle where the block was not taking input
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without work");
`endif

endmodule

### tb/alloc_ledger_pkg.sv
package alloc_ledger_pkg;

	import spr_pkg::*;

	// one result transaction as the block should produce it
	typedef struct packed {
		logic              accepted;
		logic              fell_back;
		blk_t [SLICES-1:0] alloc;
	} alloc_result_t;

	class alloc_ledger;

		blk_t              total;
		blk_t [SLICES-1:0] initial_alloc;
		blk_t [SLICES-1:0] alloc;
		alloc_result_t     owed_allocs[$];
		int                mismatches;
		int                checked;
		int                fallbacks;
		int                rejected;

		function new();
			total            = RST_TOTAL;
			initial_alloc[0] = RST_INIT0;
			initial_alloc[1] = RST_INIT1;
			initial_alloc[2] = RST_INIT2;
			alloc            = initial_alloc;
			mismatches       = 0;
			checked          = 0;
			fallbacks        = 0;
			rejected         = 0;
		endfunction

		function void set_reg(reg_idx_t idx, blk_t value);
			case (idx)
				REG_TOTAL: total            = value;
				REG_INIT0: initial_alloc[0] = value;
				REG_INIT1: initial_alloc[1] = value;
				REG_INIT2: initial_alloc[2] = value;
				default: ;
			endcase
		endfunction

		function void restore_initial();
			alloc = initial_alloc;
		endfunction

		// bring the sum back to the total; returns 1 when the initial split was restored
		function logic rebalance(logic [1:0] rot);
			int   diff;
			int   passes;
			int   m;
			int   idx;
			logic removed;
			diff   = int'(total) - (int'(alloc[0]) + int'(alloc[1]) + int'(alloc[2]));
			passes = 0;
			while (diff > 0) begin
				m = 0;
				for (int s = 1; s < SLICES; s++)
					if (alloc[s] < alloc[m])
						m = s;
				alloc[m] = alloc[m] + 1'b1;
				diff--;
			end
			while (diff < 0) begin
				removed = 1'b0;
				for (int i = 0; i < SLICES && diff < 0; i++) begin
					idx = (int'(rot) + i) % SLICES;
					if (alloc[idx] > 1) begin
						alloc[idx] = alloc[idx] - 1'b1;
						diff++;
						removed = 1'b1;
					end
				end
				if (!removed)
					break;
				passes++;
				if (passes > int'(PASS_LIMIT))
					break;
			end
			if (diff < 0 || passes > int'(PASS_LIMIT)) begin
				restore_initial();
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void note_action(logic op, logic [4:0] act, logic [1:0] rot);
			alloc_result_t r;
			int            digit[SLICES];
			int            v;
			r = '0;
			if (op) begin
				restore_initial();
				r.accepted = 1'b1;
			end else if (act < ACTION_COUNT) begin
				digit[0] = int'(act) / 9;
				digit[1] = (int'(act) / 3) % 3;
				digit[2] = int'(act) % 3;
				for (int s = 0; s < SLICES; s++) begin
					v = int'(alloc[s]) + digit[s] - 1;
					if (v < 1)
						v = 1;
					if (v > int'(MAX_BLOCKS))
						v = int'(MAX_BLOCKS);
					alloc[s] = blk_t'(v);
				end
				r.fell_back = rebalance(rot);
				r.accepted  = 1'b1;
			end else begin
				rejected++;
			end
			if (r.fell_back)
				fallbacks++;
			r.alloc = alloc;
			owed_allocs.push_back(r);
		endfunction

		function void check_alloc(logic [31:0] tdata, logic [1:0] tuser);
			alloc_result_t got;
			alloc_result_t want;
			got.accepted  = tuser[0];
			got.fell_back = tuser[1];
			for (int s = 0; s < SLICES; s++)
				got.alloc[s] = tdata[s*BLK_W +: BLK_W];
			checked++;
			if (owed_allocs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: acc %0b fb %0b alloc %0d %0d %0d",
						got.accepted, got.fell_back, got.alloc[0], got.alloc[1], got.alloc[2]);
				return;
			end
			want = owed_allocs.pop_front();
			if (got != want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d: expected acc %0b fb %0b alloc %0d %0d %0d, got acc %0b fb %0b alloc %0d %0d %0d",
						checked, want.accepted, want.fell_back,
						want.alloc[0], want.alloc[1], want.alloc[2],
						got.accepted, got.fell_back,
						got.alloc[0], got.alloc[1], got.alloc[2]);
			end
		endfunction

	endclass

endpackage

### tb/tb.sv
module tb;

	import spr_pkg::*;
	import alloc_ledger_pkg::*;

	// watchdog limit, well above what a correct run needs
	localparam int CYCLE_LIMIT = 3000000;
	localparam int HOLD_CYCLES = 300;
	localparam int RAND_PHASES = 6;
	localparam int PHASE_ITEMS = 97;
	// wait past the longest apply for stray results
	localparam int TAIL_CYCLES = 1100;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	reg_idx_t    cfg_index = REG_TOTAL;
	blk_t        cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;   // [4:0] action_id, [6:5] rotation_start, [7] zero
	logic [0:0]  s_tuser   = '0;   // [0] op
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;          // [9:0] slice0, [19:10] slice1, [29:20] slice2
	logic [1:0]  m_tuser;          // [0] accepted, [1] fell_back

	// receiver side pacing, owned by the receiver process except hold_go and idle_on
	logic idle_on   = 1'b1;
	logic hold_go   = 1'b0;
	logic hold_done = 1'b0;
	int   hold_left = 0;
	int   stall_left = 0;
	int   cycles    = 0;
	int   sent      = 0;

	alloc_ledger ledger;

	slice_prb_rebalancer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// timeout watchdog
	always @(posedge clk) cycles <= cycles + 1;

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("timeout after %0d cycles", cycles);
		$display("tb failed");
		$finish;
	end

	// sample both handshakes and the register port on the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				ledger.set_reg(cfg_index, cfg_data);
			if (s_tvalid && s_tready)
				ledger.note_action(s_tuser[0], s_tdata[4:0], s_tdata[6:5]);
			if (m_tvalid && m_tready)
				ledger.check_alloc(m_tdata, m_tuser);
		end
	end

	// receiver: short random stalls, plus one long hold-off to back up the input side
	always @(negedge clk) begin
		if (hold_go && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 2);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// offer one input transaction; called and returns at a falling edge
	task automatic push_action(input logic op, input logic [4:0] act, input logic [1:0] rot);
		int gap;
		gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, rot, act};
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		sent++;
		@(negedge clk);
	endtask

	// drop valid and wait until every owed result has come back
	task automatic settle();
		s_tvalid <= 1'b0;
		while (ledger.owed_allocs.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// write all four registers back to back while the block is idle
	task automatic program_regs(input blk_t total, input blk_t i0, input blk_t i1,
			input blk_t i2);
		cfg_we    <= 1'b1;
		cfg_index <= REG_TOTAL;
		cfg_data  <= total;
		@(negedge clk);
		cfg_index <= REG_INIT0;
		cfg_data  <= i0;
		@(negedge clk);
		cfg_index <= REG_INIT1;
		cfg_data  <= i1;
		@(negedge clk);
		cfg_index <= REG_INIT2;
		cfg_data  <= i2;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int   tot;
		int   a;
		int   b;
		logic op;
		logic [4:0] act;
		ledger = new();

		// reset held low from the start, released on a falling edge
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset configuration: reload, reload with junk id, all-minus grow, all-plus shrink
		push_action(1'b1, 5'd0, 2'd0);
		push_action(1'b1, 5'd31, 2'd3);
		push_action(1'b0, 5'd0, 2'd0);
		push_action(1'b0, 5'd26, 2'd0);
		push_action(1'b0, 5'd26, 2'd1);
		push_action(1'b0, 5'd26, 2'd2);
		// rotation start of three behaves as zero
		push_action(1'b0, 5'd26, 2'd3);
		push_action(1'b0, 5'd13, 2'd1);
		// out of range ids leave the allocation alone
		push_action(1'b0, 5'd27, 2'd2);
		push_action(1'b0, 5'd31, 2'd3);
		push_action(1'b0, 5'd9, 2'd2);
		push_action(1'b0, 5'd17, 2'd1);
		settle();

		// exactly the pass limit succeeds, one pass more falls back
		program_regs(10'd300, 10'd200, 10'd200, 10'd200);
		push_action(1'b1, 5'd0, 2'd0);
		push_action(1'b0, 5'd13, 2'd0);
		push_action(1'b1, 5'd0, 2'd0);
		push_action(1'b0, 5'd26, 2'd3);
		settle();

		// longest grow: floor at one, then add up to the full total
		program_regs(10'd1023, 10'd1, 10'd1, 10'd1);
		push_action(1'b1, 5'd0, 2'd0);
		push_action(1'b0, 5'd0, 2'd1);
		settle();

		// ceiling at 1023 and a huge overshoot falls back
		program_regs(10'd1023, 10'd1023, 10'd1023, 10'd1023);
		push_action(1'b1, 5'd0, 2'd0);
		push_action(1'b0, 5'd26, 2'd2);
		settle();

		// zero total and zero initials: removal stalls, zeros come back
		program_regs(10'd0, 10'd0, 10'd0, 10'd0);
		push_action(1'b1, 5'd0, 2'd0);
		push_action(1'b0, 5'd13, 2'd0);
		push_action(1'b0, 5'd26, 2'd1);
		settle();

		// unreachable total of two
		program_regs(10'd2, 10'd1, 10'd1, 10'd0);
		push_action(1'b1, 5'd0, 2'd0);
		push_action(1'b0, 5'd4, 2'd2);

		// random phases, each with its own register setting
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			settle();
			case (ph % 3)
				0: begin
					// consistent split of a random total
					tot = $urandom_range(3, 1023);
					a   = $urandom_range(1, tot - 2);
					b   = $urandom_range(1, tot - a - 1);
					program_regs(blk_t'(tot), blk_t'(a), blk_t'(b), blk_t'(tot - a - b));
				end
				1: program_regs(blk_t'($urandom_range(0, 1023)), blk_t'($urandom_range(0, 1023)),
					blk_t'($urandom_range(0, 1023)), blk_t'($urandom_range(0, 1023)));
				default: program_regs(blk_t'($urandom_range(0, 12)), blk_t'($urandom_range(0, 6)),
					blk_t'($urandom_range(0, 6)), blk_t'($urandom_range(0, 6)));
			endcase
			// long receiver hold-off while the sender keeps offering
			if (ph == 2)
				hold_go <= 1'b1;
			// last phase runs without any idling
			if (ph == RAND_PHASES - 1)
				idle_on <= 1'b0;
			push_action(1'b1, 5'($urandom_range(0, 31)), 2'($urandom_range(0, 3)));
			for (int n = 1; n < PHASE_ITEMS; n++) begin
				op  = ($urandom_range(0, 11) == 0);
				act = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(27, 31))
				                                  : 5'($urandom_range(0, 26));
				if (op)
					act = 5'($urandom_range(0, 31));
				push_action(op, act, 2'($urandom_range(0, 3)));
			end
		end

		// drain, then look out for anything extra
		settle();
		repeat (TAIL_CYCLES) @(negedge clk);

		if (ledger.owed_allocs.size() != 0)
			$display("%0d results never arrived", ledger.owed_allocs.size());
		$display("covered %0d transactions in, %0d results checked, %0d fallbacks, %0d rejected ids",
			sent, ledger.checked, ledger.fallbacks, ledger.rejected);
		$display("mismatches %0d over %0d cycles", ledger.mismatches, cycles);
		if (ledger.mismatches == 0 && ledger.owed_allocs.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
